/* hw/rtl/wrc_pkg.sv */
// ----------------------------------------------------------------------------
// wrc_pkg: shared types and constants of the waterfall row colouriser
// Holds the level format, the register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package wrc_pkg;

  localparam int MagFracBits = 24;
  localparam int LvlW        = 26;
  localparam int OneDb       = 65536;
  localparam int DbK         = 394566;

  localparam logic signed [LvlW-1:0] LevelMin   = LvlW'(-200 * OneDb);
  localparam logic signed [LvlW-1:0] LevelMax   = LvlW'(200 * OneDb);
  localparam logic signed [LvlW-1:0] MinRange   = LvlW'(20 * OneDb);
  localparam logic signed [LvlW-1:0] PeakReset  = LvlW'(-40 * OneDb);
  localparam logic signed [LvlW-1:0] FloorReset = LvlW'(-80 * OneDb);

  localparam logic [1:0] RegGain   = 2'd0;
  localparam logic [1:0] RegAttack = 2'd1;
  localparam logic [1:0] RegDecay  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_NORM,
    S_LOG,
    S_SCALE,
    S_ROUND,
    S_TRACK_PEAK,
    S_TRACK_FLOOR,
    S_PREP,
    S_DIV,
    S_COLOR,
    S_OUT
  } state_t;

endpackage

/* hw/rtl/wrc_if.sv */
// ----------------------------------------------------------------------------
// wrc_if: valid/ready channel
// Carries one beat of a payload type between a source and a sink.
// ----------------------------------------------------------------------------
interface wrc_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/waterfall_row_colorizer_agc.sv */
// ----------------------------------------------------------------------------
// waterfall_row_colorizer_agc: dB conversion, gain tracking and colour ramp
// Converts a column magnitude to dB, tracks the row levels and colours pixels.
// ----------------------------------------------------------------------------
// A measure column passes through the accept state, a normalise step, the log2
// fraction steps through the shared squaring multiplier, a scale and a rounding
// step before the block is ready again. The last measure column of a row adds
// the peak and floor tracking multiplies. A colorize column skips the 11-step
// restoring divider when the level clamps to either end of the ramp, and the
// finished pixel waits in its output register until taken. A zero magnitude
// skips the log and scale steps. The block takes one beat at a time.
module waterfall_row_colorizer_agc
  import wrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              action,
  input  logic [31:0]       magnitude,
  input  logic              is_last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        red,
  output logic [7:0]        green,
  output logic [7:0]        blue
);

  state_t state, state_next;

  logic signed [6:0]  gain_db;
  logic [15:0]        attack_coef, decay_coef;
  logic signed [LvlW-1:0] peak_level, floor_level, row_max, row_min, lvl;
  logic signed [LvlW-1:0] lvl_c;
  logic               act_r, last_r;
  logic [32:0]        m;
  logic [4:0]         p;
  logic [4:0]         cnt;
  logic signed [22:0] l;
  logic signed [63:0] acc;
  logic signed [LvlW+1:0] rng, n;
  logic signed [LvlW+1:0] n_c, rng_c, span;
  logic [37:0]        prod;
  logic [37:0]        rem;
  logic [10:0]        dlo;
  logic [10:0]        q;
  logic               inexact;

  // One shared multiplier, operands chosen by the sequencer state.
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  assign mul_p = mul_a * mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_LOG:   begin mul_a = {1'b0, m}; mul_b = {1'b0, m}; end
      S_SCALE: begin mul_a = 34'(l); mul_b = 34'(DbK); end
      S_TRACK_PEAK: begin
        mul_a = (row_max > peak_level) ? {18'd0, attack_coef} : {18'd0, decay_coef};
        mul_b = 34'(row_max) - 34'(peak_level);
      end
      S_TRACK_FLOOR: begin
        mul_a = (row_min < floor_level) ? {18'd0, attack_coef} : {18'd0, decay_coef};
        mul_b = 34'(row_min) - 34'(floor_level);
      end
      default: ;
    endcase
  end

  logic [32:0] sq;
  assign sq = 33'(mul_p >>> 31);

  logic [4:0] msb;
  always_comb begin
    msb = '0;
    for (int i = 0; i < 32; i++) if (magnitude[i]) msb = 5'(i);
  end

  logic signed [47:0] rnd;
  assign rnd = 48'((acc + 64'sd32768) >>> 16);

  // A zero magnitude skips the log and lands exactly on the bottom level.
  assign lvl_c = (m == '0) ? LevelMin : LvlW'(rnd);

  assign span  = 28'(peak_level) - 28'(floor_level);
  assign rng_c = (span < 28'(MinRange)) ? 28'(MinRange) : span;
  assign n_c   = 28'(lvl) + 28'(gain_db) * 28'(OneDb) - 28'(floor_level);

  // The dividend is 1020 times the normalised level; its top bits preload the
  // remainder, which stays below the range, and the low 11 bits are shifted in.
  assign prod = (38'(n_c) << 10) - (38'(n_c) << 2);

  logic [37:0] trial;
  assign trial = {rem[36:0], dlo[10]} - {10'd0, rng};

  assign inexact = (rem != '0) && (n > 0) && (n < rng);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_NORM;
      S_NORM:  state_next = (m == '0) ? S_ROUND : S_LOG;
      S_LOG:   if (cnt == 5'd15) state_next = S_SCALE;
      S_SCALE: state_next = S_ROUND;
      S_ROUND: state_next = act_r ? S_PREP : (last_r ? S_TRACK_PEAK : S_IDLE);
      S_TRACK_PEAK:  state_next = S_TRACK_FLOOR;
      S_TRACK_FLOOR: state_next = S_IDLE;
      S_PREP:  state_next = (n_c <= 0 || n_c >= rng_c) ? S_COLOR : S_DIV;
      S_DIV:   if (cnt == 5'd10) state_next = S_COLOR;
      S_COLOR: state_next = S_OUT;
      S_OUT:   if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  logic [10:0] t;
  always_comb begin
    t = q;
    if (n <= 0) t = '0;
    else if (n >= rng) t = 11'd1020;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      gain_db     <= '0;
      attack_coef <= 16'd3277;
      decay_coef  <= 16'd131;
      peak_level  <= PeakReset;
      floor_level <= FloorReset;
      row_max     <= LevelMin;
      row_min     <= LevelMax;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          RegGain: begin
            if ($signed(cfg_data[6:0]) > 7'sd60) gain_db <= 7'sd60;
            else if ($signed(cfg_data[6:0]) < -7'sd60) gain_db <= -7'sd60;
            else gain_db <= $signed(cfg_data[6:0]);
          end
          RegAttack: attack_coef <= cfg_data;
          RegDecay:  decay_coef <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        S_ROUND: if (!act_r) begin
          if (lvl_c > row_max) row_max <= lvl_c;
          if (lvl_c < row_min) row_min <= lvl_c;
        end
        S_TRACK_PEAK: begin
          peak_level <= peak_level + LvlW'((mul_p + 68'sd32768) >>> 16);
          row_max <= LevelMin;
        end
        S_TRACK_FLOOR: begin
          floor_level <= floor_level + LvlW'((mul_p + 68'sd32768) >>> 16);
          row_min <= LevelMax;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (in_valid) begin
        act_r  <= action;
        last_r <= is_last;
        p      <= msb;
        m      <= 33'({1'b0, magnitude} << (5'd31 - msb));
        cnt    <= '0;
        l      <= '0;
      end
      S_NORM: ;
      S_LOG: begin
        cnt <= cnt + 5'd1;
        if (sq[32]) begin m <= sq >> 1; l <= {l[21:0], 1'b1}; end
        else begin m <= sq; l <= {l[21:0], 1'b0}; end
      end
      S_SCALE: acc <= 64'(mul_p[56:0]) + 64'((64'($signed({1'b0, p})) - 64'(MagFracBits)) * DbK * 65536);
      S_ROUND: begin
        lvl <= lvl_c;
        cnt <= '0;
      end
      S_PREP: begin
        n   <= n_c;
        rng <= rng_c;
        rem <= {11'd0, prod[37:11]};
        dlo <= prod[10:0];
        q   <= '0;
      end
      S_DIV: begin
        cnt <= cnt + 5'd1;
        dlo <= {dlo[9:0], 1'b0};
        if (!trial[37]) begin rem <= trial; q <= {q[9:0], 1'b1}; end
        else begin rem <= {rem[36:0], dlo[10]}; q <= {q[9:0], 1'b0}; end
      end
      S_COLOR: begin
        if (t < 11'd255) begin red <= 8'd0; green <= 8'd0; blue <= t[7:0]; end
        else if (t < 11'd510) begin red <= 8'd0; green <= 8'(t - 11'd255); blue <= 8'd255; end
        else if (t < 11'd765) begin
          red <= 8'(t - 11'd510); green <= 8'd255; blue <= 8'(11'd765 - t - 11'(inexact));
        end else begin
          red <= 8'd255; green <= 8'(11'd1020 - t - 11'(inexact)); blue <= 8'd0;
        end
      end
      default: ;
    endcase
  end

endmodule

/* tb/sv/wrc_tb_pkg.sv */
// ----------------------------------------------------------------------------
// wrc_tb_pkg: beat types of the colouriser testbench
// Column and pixel payloads carried on the valid/ready channels.
// ----------------------------------------------------------------------------
package wrc_tb_pkg;

  typedef struct packed {
    logic        action;
    logic [31:0] magnitude;
    logic        is_last;
  } column_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  localparam logic ActMeasure  = 1'b0;
  localparam logic ActColorize = 1'b1;
  localparam logic [1:0] RegUnused = 2'd3;

endpackage

/* tb/sv/wrc_checker.sv */
// ----------------------------------------------------------------------------
// wrc_checker: pixel predictor and scoreboard
// Mirrors the dB conversion, gain tracking and colour ramp for every accepted
// column and compares each accepted pixel with the oldest expected one.
// ----------------------------------------------------------------------------
module wrc_checker
  import wrc_pkg::*;
  import wrc_tb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  wrc_if              col_bus,
  wrc_if              pix_bus,
  output int          fail_count,
  output int          pixels_owed
);

  logic signed [6:0] gain;
  logic [15:0]       attack;
  logic [15:0]       decay;
  longint            peak;
  longint            flr;
  longint            row_hi;
  longint            row_lo;
  pixel_t            pixel_q[$];

  function automatic longint db_of(logic [31:0] mag);
    int          p;
    logic [63:0] m;
    longint      l;
    if (mag == 0) return longint'(-200) * OneDb;
    p = 31;
    while (!mag[p]) p--;
    m = {32'b0, mag} << (31 - p);
    l = 0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 31;
      l = l <<< 1;
      if (m[32]) begin
        m = m >> 1;
        l = l | 1;
      end
    end
    l = l + (longint'(p) - MagFracBits) * 65536;
    return (l * DbK + 32768) >>> 16;
  endfunction

  function automatic longint nudge(longint cur, longint tgt, logic [15:0] c);
    return cur + ((longint'(c) * (tgt - cur) + 32768) >>> 16);
  endfunction

  function automatic pixel_t paint(longint lvl);
    longint span, n, t, e, r, g, b;
    pixel_t px;
    span = peak - flr;
    if (span < 20 * 65536) span = 20 * 65536;
    n = lvl + longint'(gain) * 65536 - flr;
    e = 0;
    if (n <= 0) t = 0;
    else if (n >= span) t = 1020;
    else begin
      t = (n * 1020) / span;
      e = ((n * 1020) % span) != 0;
    end
    if (t < 255) begin
      r = 0; g = 0; b = t;
    end else if (t < 510) begin
      r = 0; g = t - 255; b = 255;
    end else if (t < 765) begin
      r = t - 510; g = 255; b = 765 - t - e;
    end else begin
      r = 255; g = 1020 - t - e; b = 0;
    end
    px.red = r[7:0];
    px.green = g[7:0];
    px.blue = b[7:0];
    return px;
  endfunction

  always @(posedge clk) begin : predict
    longint lvl;
    int     gv;
    pixel_t want;
    if (rst) begin
      gain = 0;
      attack = 16'd3277;
      decay = 16'd131;
      peak = longint'(-40) * OneDb;
      flr = longint'(-80) * OneDb;
      row_hi = longint'(-200) * OneDb;
      row_lo = longint'(200) * OneDb;
      pixel_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegGain: begin
            gv = $signed(cfg_data[6:0]);
            if (gv > 60) gv = 60;
            if (gv < -60) gv = -60;
            gain = 7'(gv);
          end
          RegAttack: attack = cfg_data;
          RegDecay: decay = cfg_data;
          default: ;
        endcase
      end
      if (pix_bus.valid && pix_bus.ready) begin
        if (pixel_q.size() == 0) begin
          $error("pixel beat with none expected");
          fail_count++;
        end else begin
          want = pixel_q.pop_front();
          if (pix_bus.data.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, pix_bus.data.red);
            fail_count++;
          end
          if (pix_bus.data.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, pix_bus.data.green);
            fail_count++;
          end
          if (pix_bus.data.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, pix_bus.data.blue);
            fail_count++;
          end
        end
      end
      if (col_bus.valid && col_bus.ready) begin
        lvl = db_of(col_bus.data.magnitude);
        if (col_bus.data.action == ActMeasure) begin
          if (lvl > row_hi) row_hi = lvl;
          if (lvl < row_lo) row_lo = lvl;
          if (col_bus.data.is_last) begin
            peak = nudge(peak, row_hi, (row_hi > peak) ? attack : decay);
            flr = nudge(flr, row_lo, (row_lo < flr) ? attack : decay);
            row_hi = longint'(-200) * OneDb;
            row_lo = longint'(200) * OneDb;
          end
        end else begin
          pixel_q.push_back(paint(lvl));
        end
      end
    end
    pixels_owed = pixel_q.size();
  end

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: testbench of the waterfall row colouriser
// Sends rows twice, measure then colorize, or in one mode, under several
// register settings, idle and stall patterns, and reports the pixel checker verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import wrc_pkg::*;
  import wrc_tb_pkg::*;

  localparam int CycleLimit = 2000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = RegGain;
  logic [15:0] cfg_data = '0;
  int          fail_count;
  int          pixels_owed;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          cycles = 0;
  int          sent = 0;

  wrc_if #(.payload_t(column_t)) col_if ();
  wrc_if #(.payload_t(pixel_t))  pix_if ();

  waterfall_row_colorizer_agc u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (col_if.valid),
    .in_ready  (col_if.ready),
    .action    (col_if.data.action),
    .magnitude (col_if.data.magnitude),
    .is_last   (col_if.data.is_last),
    .out_valid (pix_if.valid),
    .out_ready (pix_if.ready),
    .red       (pix_if.data.red),
    .green     (pix_if.data.green),
    .blue      (pix_if.data.blue)
  );

  wrc_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .col_bus     (col_if),
    .pix_bus     (pix_if),
    .fail_count  (fail_count),
    .pixels_owed (pixels_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) pix_if.ready <= 1'b0;
    else pix_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic send_column(logic act, logic [31:0] mag, logic lst);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      col_if.valid = 1'b0;
      @(negedge clk);
    end
    col_if.valid = 1'b1;
    col_if.data = '{action: act, magnitude: mag, is_last: lst};
    @(posedge clk);
    while (!col_if.ready) @(posedge clk);
    sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    col_if.valid = 1'b0;
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Measure columns give no pixel, so some slack follows the last one.
  task automatic settle();
    @(negedge clk);
    col_if.valid = 1'b0;
    while (pixels_owed != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_mag();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom;
      default: return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  initial begin : stimulus
    logic [31:0] mags[16];
    int          w;
    logic [15:0] gain_set[4];
    logic [15:0] atk_set[4];
    logic [15:0] dec_set[4];
    int          idle_set[4];
    int          stall_set[4];

    gain_set  = '{16'h003C, 16'hFF40, 16'h007F, 16'h0044};
    atk_set   = '{16'd0, 16'hFFFF, 16'd3277, 16'd20000};
    dec_set   = '{16'hFFFF, 16'd0, 16'd131, 16'd700};
    idle_set  = '{0, 76, 0, 11};
    stall_set = '{0, 0, 76, 11};

    col_if.valid = 1'b0;
    col_if.data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: field extremes at reset settings, last flag in both modes.
    send_column(ActColorize, 32'h0, 1'b0);
    send_column(ActColorize, 32'hFFFF_FFFF, 1'b1);
    send_column(ActColorize, 32'h1, 1'b0);
    send_column(ActColorize, 32'h0100_0000, 1'b0);
    send_column(ActColorize, 32'h0000_0100, 1'b1);
    send_column(ActMeasure, 32'h0, 1'b0);
    send_column(ActMeasure, 32'hFFFF_FFFF, 1'b1);
    send_column(ActColorize, 32'h0100_0000, 1'b0);
    send_column(ActMeasure, 32'h0000_0001, 1'b1);
    send_column(ActColorize, 32'h8000_0000, 1'b0);
    // A flat row tracked several times moves peak and floor toward its level.
    for (int i = 0; i < 4; i++) send_column(ActMeasure, 32'h0001_0000, 1'b1);
    send_column(ActColorize, 32'h0001_0000, 1'b0);
    send_column(ActColorize, 32'h0002_0000, 1'b0);
    settle();
    write_reg(RegUnused, 16'hFFFF);
    send_column(ActColorize, 32'h0400_0000, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      settle();
      write_reg(RegGain, gain_set[ph]);
      write_reg(RegAttack, atk_set[ph]);
      write_reg(RegDecay, dec_set[ph]);
      idle_pct = idle_set[ph];
      stall_pct = stall_set[ph];
      for (int k = 0; k < 2; k++) begin
        if (k == 1) begin
          settle();
          write_reg(RegGain, 16'($urandom));
          write_reg(RegAttack, 16'($urandom));
          write_reg(RegDecay, 16'($urandom_range(0, 4000)));
        end
        while (sent < 20 + ph * 300 + (k + 1) * 150) begin
          w = $urandom_range(1, 12);
          for (int c = 0; c < w; c++) mags[c] = pick_mag();
          case ($urandom_range(9))
            7: for (int c = 0; c < w; c++)
                 send_column(ActColorize, mags[c], 1'($urandom));
            8: for (int c = 0; c < w; c++)
                 send_column(ActMeasure, mags[c], 1'($urandom_range(3) == 0));
            9: send_column(1'($urandom), $urandom, 1'($urandom));
            default: begin
              for (int c = 0; c < w; c++) send_column(ActMeasure, mags[c], c == w - 1);
              for (int c = 0; c < w; c++) send_column(ActColorize, mags[c], c == w - 1);
            end
          endcase
        end
      end
    end

    settle();
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
